// File: sv/fms_pkg.sv
// ----------------------------------------------------------------------------
// fms_pkg: shared types, constants and helpers of the fuzzy match scorer
// Command and status codes, field widths, scoring bonuses, ASCII case tests.
// ----------------------------------------------------------------------------
package fms_pkg;

  // pattern capacity and derived widths
  localparam int PATTERN_MAX = 32;
  localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int CNT_W  = $clog2(PATTERN_MAX + 2);
  localparam int RUN_W  = LEN_W;
  localparam int GAIN_W = $clog2(5 * PATTERN_MAX + 11);

  // payload widths
  localparam int CMD_W   = 2;
  localparam int CP_W    = 21;
  localparam int SCORE_W = 16;
  localparam int STAT_W  = 2;

  typedef logic [CMD_W-1:0]   cmd_t;
  typedef logic [CP_W-1:0]    cp_t;
  typedef logic [SCORE_W-1:0] score_t;
  typedef logic [STAT_W-1:0]  status_t;
  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [RUN_W-1:0]   run_t;
  typedef logic [GAIN_W-1:0]  gain_t;

  // request commands
  localparam cmd_t CMD_APPEND = 2'd0;
  localparam cmd_t CMD_CLEAR  = 2'd1;
  localparam cmd_t CMD_TARGET = 2'd2;

  // result status codes
  localparam status_t STAT_OK       = 2'd0;
  localparam status_t STAT_EMPTY    = 2'd1;
  localparam status_t STAT_SHORT    = 2'd2;
  localparam status_t STAT_OVERFLOW = 2'd3;

  localparam len_t   LEN_FULL  = len_t'(PATTERN_MAX);
  localparam cnt_t   CNT_SAT   = cnt_t'(PATTERN_MAX + 1);
  localparam score_t SCORE_SAT = '1;

  // separator characters
  localparam cp_t CH_BSLASH = 21'h5C;
  localparam cp_t CH_SLASH  = 21'h2F;
  localparam cp_t CH_SPACE  = 21'h20;
  localparam cp_t CH_UNDER  = 21'h5F;
  localparam cp_t CH_DOT    = 21'h2E;

  // position bonuses
  localparam logic [3:0] BONUS_FIRST = 4'd8;
  localparam logic [3:0] BONUS_SLASH = 4'd5;
  localparam logic [3:0] BONUS_SPACE = 4'd4;
  localparam logic [3:0] BONUS_DOT   = 4'd3;
  localparam logic [3:0] BONUS_CAMEL = 4'd4;

  // controller to datapath
  typedef struct packed {
    logic take;         // request accepted this cycle
    logic load_result;  // capture result into the output register
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic makes_result; // offered request ends a target
  } dp_stat_t;

  function automatic logic is_upper(cp_t c);
    return (c >= 21'h41) && (c <= 21'h5A);
  endfunction

  function automatic logic is_lower(cp_t c);
    return (c >= 21'h61) && (c <= 21'h7A);
  endfunction

  function automatic cp_t fold_lower(cp_t c);
    return is_upper(c) ? (c + 21'd32) : c;
  endfunction

endpackage

// File: sv/fms_in_if.sv
// ----------------------------------------------------------------------------
// fms_in_if: request channel of the fuzzy match scorer
// Valid/ready handshake with command, code point and end-of-target flag.
// ----------------------------------------------------------------------------
interface fms_in_if;
  logic            valid;
  logic            ready;
  fms_pkg::cmd_t   cmd;
  fms_pkg::cp_t    code_point;
  logic            end_of_target;

  modport source (output valid, output cmd, output code_point, output end_of_target,
                  input ready);
  modport sink   (input valid, input cmd, input code_point, input end_of_target,
                  output ready);
endinterface

// File: sv/fms_out_if.sv
// ----------------------------------------------------------------------------
// fms_out_if: result channel of the fuzzy match scorer
// Valid/ready handshake with final score and status.
// ----------------------------------------------------------------------------
interface fms_out_if;
  logic              valid;
  logic              ready;
  fms_pkg::score_t   match_score;
  fms_pkg::status_t  status;

  modport source (output valid, output match_score, output status, input ready);
  modport sink   (input valid, input match_score, input status, output ready);
endinterface

// File: sv/fms_ctrl.sv
// ----------------------------------------------------------------------------
// fms_ctrl: handshake controller of the fuzzy match scorer
// Tracks the output register and decides when a request is taken.
// ----------------------------------------------------------------------------
module fms_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  fms_pkg::dp_stat_t   stat,
  output fms_pkg::ctl_cmd_t   ctl
);

  localparam logic ST_EMPTY = 1'b0;
  localparam logic ST_FULL  = 1'b1;

  logic state_r, state_nxt;

  // take a request when the result slot is free or drains this cycle
  assign in_ready        = (state_r == ST_EMPTY) || out_ready;
  assign out_valid       = (state_r == ST_FULL);
  assign ctl.take        = in_valid && in_ready;
  assign ctl.load_result = ctl.take && stat.makes_result;

  // result slot occupancy
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_EMPTY: begin
        if (ctl.load_result) state_nxt = ST_FULL;
      end
      ST_FULL: begin
        if (out_ready && !ctl.load_result) state_nxt = ST_EMPTY;
      end
      default: begin
        state_nxt = ST_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

  // a result is only loaded from an accepted request
  a_load_needs_take: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_result |-> ctl.take)
    else $error("result loaded without accepted request");

  // a loaded result is presented next cycle
  a_load_fills: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_result |=> out_valid)
    else $error("loaded result not presented");

  // a pending result that is not taken stays
  a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("pending result dropped");

endmodule

// File: sv/fms_datapath.sv
// ----------------------------------------------------------------------------
// fms_datapath: pattern store and score column of the fuzzy match scorer
// One cell per pattern row updates score and run length for each target char.
// ----------------------------------------------------------------------------
module fms_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  fms_pkg::ctl_cmd_t   ctl,
  output fms_pkg::dp_stat_t   stat,
  input  fms_pkg::cmd_t       in_cmd,
  input  fms_pkg::cp_t        in_code_point,
  input  logic                in_end_of_target,
  output fms_pkg::score_t     out_match_score,
  output fms_pkg::status_t    out_status
);

  fms_pkg::cp_t     pat_chars_r [fms_pkg::PATTERN_MAX];
  fms_pkg::len_t    pat_len_r;
  logic             pat_ovf_r;
  fms_pkg::score_t  score_r     [fms_pkg::PATTERN_MAX];
  fms_pkg::run_t    run_r       [fms_pkg::PATTERN_MAX];
  fms_pkg::cp_t     prev_cp_r;
  fms_pkg::cnt_t    tcount_r;
  fms_pkg::score_t  res_score_r;
  fms_pkg::status_t res_status_r;

  fms_pkg::score_t  score_nxt   [fms_pkg::PATTERN_MAX];
  fms_pkg::run_t    run_nxt     [fms_pkg::PATTERN_MAX];
  logic             row_en      [fms_pkg::PATTERN_MAX];

  logic             first;
  fms_pkg::cp_t     fold_tc;
  logic [3:0]       bonus;
  fms_pkg::cnt_t    tcount_inc;
  logic             pat_wr;
  fms_pkg::len_t    last_row;
  fms_pkg::score_t  res_score_nxt;
  fms_pkg::status_t res_status_nxt;

  assign stat.makes_result = (in_cmd == fms_pkg::CMD_TARGET) && in_end_of_target;

  // column-wide terms shared by all cells
  assign first   = (tcount_r == '0);
  assign fold_tc = fms_pkg::fold_lower(in_code_point);

  always_comb begin
    if (first) begin
      bonus = fms_pkg::BONUS_FIRST;
    end else if ((prev_cp_r == fms_pkg::CH_BSLASH) || (prev_cp_r == fms_pkg::CH_SLASH)) begin
      bonus = fms_pkg::BONUS_SLASH;
    end else if ((prev_cp_r == fms_pkg::CH_SPACE) || (prev_cp_r == fms_pkg::CH_UNDER)) begin
      bonus = fms_pkg::BONUS_SPACE;
    end else if (prev_cp_r == fms_pkg::CH_DOT) begin
      bonus = fms_pkg::BONUS_DOT;
    end else if (fms_pkg::is_lower(prev_cp_r) && fms_pkg::is_upper(in_code_point)) begin
      bonus = fms_pkg::BONUS_CAMEL;
    end else begin
      bonus = '0;
    end
  end

  // one cell per pattern row
  for (genvar p = 0; p < fms_pkg::PATTERN_MAX; p++) begin : g_cell
    fms_pkg::score_t diag_src, left, diag, total_sat;
    fms_pkg::run_t   run_src, run;
    fms_pkg::gain_t  gain;
    logic [fms_pkg::SCORE_W:0] total;
    logic            hit, exact, win;

    if (p == 0) begin : g_top
      assign diag_src = '0;
      assign run_src  = '0;
    end else begin : g_mid
      assign diag_src = score_r[p-1];
      assign run_src  = run_r[p-1];
    end

    assign row_en[p] = (fms_pkg::len_t'(p) < pat_len_r);

    always_comb begin
      left  = first ? '0 : score_r[p];
      diag  = first ? '0 : diag_src;
      run   = first ? '0 : run_src;
      exact = (pat_chars_r[p] == in_code_point);
      hit   = (fms_pkg::fold_lower(pat_chars_r[p]) == fold_tc) && ((diag != '0) || (p == 0));
      // gain = 1 + 5*run + exact + bonus
      gain  = hit ? (fms_pkg::gain_t'(1)
                     + (fms_pkg::gain_t'(run) << 2) + fms_pkg::gain_t'(run)
                     + fms_pkg::gain_t'(exact) + fms_pkg::gain_t'(bonus))
                  : '0;
      total     = {1'b0, diag} + (fms_pkg::SCORE_W+1)'(gain);
      total_sat = total[fms_pkg::SCORE_W] ? fms_pkg::SCORE_SAT : total[fms_pkg::SCORE_W-1:0];
      win       = hit && (left <= total_sat);
      score_nxt[p] = win ? total_sat : left;
      run_nxt[p]   = win ? (run + fms_pkg::run_t'(1)) : '0;
    end
  end

  assign tcount_inc = (tcount_r < fms_pkg::CNT_SAT) ? (tcount_r + fms_pkg::cnt_t'(1)) : tcount_r;
  assign pat_wr     = ctl.take && (in_cmd == fms_pkg::CMD_APPEND) && (pat_len_r < fms_pkg::LEN_FULL);
  assign last_row   = pat_len_r - fms_pkg::len_t'(1);

  // result from the column after this character
  always_comb begin
    res_score_nxt = '0;
    if (pat_len_r == '0) begin
      res_status_nxt = fms_pkg::STAT_EMPTY;
    end else if (pat_ovf_r) begin
      res_status_nxt = fms_pkg::STAT_OVERFLOW;
    end else if (fms_pkg::cnt_t'(pat_len_r) > tcount_inc) begin
      res_status_nxt = fms_pkg::STAT_SHORT;
    end else begin
      res_status_nxt = fms_pkg::STAT_OK;
      res_score_nxt  = score_nxt[last_row[fms_pkg::IDX_W-1:0]];
    end
  end

  // pattern characters
  always_ff @(posedge clk) begin
    if (pat_wr) begin
      pat_chars_r[pat_len_r[fms_pkg::IDX_W-1:0]] <= in_code_point;
    end
  end

  // pattern length, overflow and score column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r <= '0;
      pat_ovf_r <= 1'b0;
      prev_cp_r <= '0;
      tcount_r  <= '0;
      for (int i = 0; i < fms_pkg::PATTERN_MAX; i++) begin
        score_r[i] <= '0;
        run_r[i]   <= '0;
      end
    end else if (ctl.take) begin
      case (in_cmd)
        fms_pkg::CMD_APPEND, fms_pkg::CMD_CLEAR: begin
          if (in_cmd == fms_pkg::CMD_CLEAR) begin
            pat_len_r <= '0;
            pat_ovf_r <= 1'b0;
          end else if (pat_wr) begin
            pat_len_r <= pat_len_r + fms_pkg::len_t'(1);
          end else begin
            pat_ovf_r <= 1'b1;
          end
          prev_cp_r <= '0;
          tcount_r  <= '0;
          for (int i = 0; i < fms_pkg::PATTERN_MAX; i++) begin
            score_r[i] <= '0;
            run_r[i]   <= '0;
          end
        end
        fms_pkg::CMD_TARGET: begin
          if (in_end_of_target) begin
            prev_cp_r <= '0;
            tcount_r  <= '0;
            for (int i = 0; i < fms_pkg::PATTERN_MAX; i++) begin
              score_r[i] <= '0;
              run_r[i]   <= '0;
            end
          end else begin
            prev_cp_r <= in_code_point;
            tcount_r  <= tcount_inc;
            for (int i = 0; i < fms_pkg::PATTERN_MAX; i++) begin
              if (row_en[i]) begin
                score_r[i] <= score_nxt[i];
                run_r[i]   <= run_nxt[i];
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (ctl.load_result) begin
      res_score_r  <= res_score_nxt;
      res_status_r <= res_status_nxt;
    end
  end

  assign out_match_score = res_score_r;
  assign out_status      = res_status_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pat_len_r <= fms_pkg::LEN_FULL)
    else $error("pattern length beyond capacity");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tcount_r <= fms_pkg::CNT_SAT)
    else $error("target count beyond saturation");

  a_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_result |=> (tcount_r == '0) && (prev_cp_r == '0))
    else $error("target state not cleared after result");

endmodule

// File: sv/fuzzy_match_scorer_core.sv
// ----------------------------------------------------------------------------
// fuzzy_match_scorer_core: fuzzy subsequence match scorer, top level
// Loads a pattern, scores a streamed target, returns one score per target.
// ----------------------------------------------------------------------------
//  channel  | role   | handshake     | payload
//  ---------+--------+---------------+-------------------------------------
//  in_ch    | sink   | valid / ready | cmd, code_point, end_of_target
//  out_ch   | source | valid / ready | match_score, status
//
//  One request per clock while the output register can take a result: all
//  pattern rows update in parallel cells in the cycle the request is accepted.
//  A result appears in the output register in the cycle after its request.
//  While a result waits untaken, every request is held off: in_ch.ready
//  follows out_ch.ready whenever the output register is full.
//  Reset is synchronous, active low, and leaves the pattern empty.
// ----------------------------------------------------------------------------
module fuzzy_match_scorer_core (
  input  logic        clk,
  input  logic        rst_n,
  fms_in_if.sink      in_ch,
  fms_out_if.source   out_ch
);

  fms_pkg::ctl_cmd_t ctl;
  fms_pkg::dp_stat_t stat;

  // handshake controller
  fms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // pattern store and score column
  fms_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .stat             (stat),
    .in_cmd           (in_ch.cmd),
    .in_code_point    (in_ch.code_point),
    .in_end_of_target (in_ch.end_of_target),
    .out_match_score  (out_ch.match_score),
    .out_status       (out_ch.status)
  );

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the fuzzy match scorer core
// Loads patterns and streams target characters through the request channel.
// A scoreboard class recomputes the scoring columns for every accepted
// request and compares each returned score and status in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fms_pkg::*;

  // command code that the block ignores
  localparam cmd_t CMD_UNUSED = 2'd3;

  localparam int  ITEM_GOAL    = 1800;
  localparam int  IDLE_LIMIT   = 1000;
  localparam int  HOLD_CYCLES  = 80;
  localparam int  DRAIN_CYCLES = 8;
  localparam cp_t CP_TOP       = 21'h10FFFF;

  typedef struct packed {
    score_t  score;
    status_t status;
  } score_result_t;

  // scoring columns and pattern kept in step with the block
  class match_scoreboard;
    cp_t           pat [PATTERN_MAX];
    len_t          pat_len;
    bit            overflow;
    score_t        row_score [PATTERN_MAX];
    run_t          row_run [PATTERN_MAX];
    cp_t           prev_char;
    cnt_t          col_count;
    score_result_t due_scores [$];
    int            errors;

    function new();
      pat_len  = '0;
      overflow = 1'b0;
      errors   = 0;
      foreach (pat[i]) pat[i] = '0;
      clear_columns();
    endfunction

    function void clear_columns();
      foreach (row_score[i]) begin
        row_score[i] = '0;
        row_run[i]   = '0;
      end
      prev_char = '0;
      col_count = '0;
    endfunction

    // ascii-only case folding
    function cp_t fold(cp_t c);
      return (c >= 21'h41 && c <= 21'h5A) ? c + 21'd32 : c;
    endfunction

    // score a match of pattern char pc against target char tc
    function int cell_gain(cp_t pc, cp_t tc, bit first, int run);
      int g;
      if (fold(pc) != fold(tc)) return 0;
      g = 1 + run * 5;
      if (pc == tc) g += 1;
      if (first) g += BONUS_FIRST;
      else if (prev_char == CH_BSLASH || prev_char == CH_SLASH) g += BONUS_SLASH;
      else if (prev_char == CH_SPACE || prev_char == CH_UNDER) g += BONUS_SPACE;
      else if (prev_char == CH_DOT) g += BONUS_DOT;
      else if (prev_char >= 21'h61 && prev_char <= 21'h7A && tc >= 21'h41 && tc <= 21'h5A)
        g += BONUS_CAMEL;
      return g;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    // update the model for one accepted request
    function void take_request(cmd_t cmd, cp_t cp, logic eot);
      score_result_t res;
      int            left_v, diag, run_v, gain, total;
      bit            first;
      len_t          last_row;
      case (cmd)
        CMD_APPEND: begin
          if (pat_len < PATTERN_MAX) begin
            pat[pat_len[IDX_W-1:0]] = cp;
            pat_len++;
          end else begin
            overflow = 1'b1;
          end
          clear_columns();
        end
        CMD_CLEAR: begin
          pat_len  = '0;
          overflow = 1'b0;
          clear_columns();
        end
        CMD_TARGET: begin
          first = (col_count == 0);
          // walk rows downward so the row above still holds the old column
          for (int p = int'(pat_len) - 1; p >= 0; p--) begin
            left_v = first ? 0 : int'(row_score[p]);
            diag   = (first || p == 0) ? 0 : int'(row_score[p-1]);
            run_v  = (first || p == 0) ? 0 : int'(row_run[p-1]);
            gain   = 0;
            if (diag != 0 || p == 0) gain = cell_gain(pat[p], cp, first, run_v);
            total = diag + gain;
            if (total > int'(SCORE_SAT)) total = int'(SCORE_SAT);
            if (gain != 0 && left_v <= total) begin
              row_run[p]   = run_t'(run_v + 1);
              row_score[p] = score_t'(total);
            end else begin
              row_run[p]   = '0;
              row_score[p] = score_t'(left_v);
            end
          end
          prev_char = cp;
          if (col_count < CNT_SAT) col_count++;
          if (eot) begin
            res.score = '0;
            if (pat_len == 0) begin
              res.status = STAT_EMPTY;
            end else if (overflow) begin
              res.status = STAT_OVERFLOW;
            end else if (pat_len > col_count) begin
              res.status = STAT_SHORT;
            end else begin
              res.status = STAT_OK;
              last_row   = pat_len - len_t'(1);
              res.score  = row_score[last_row[IDX_W-1:0]];
            end
            due_scores.insert(due_scores.size(), res);
            clear_columns();
          end
        end
        default: ;
      endcase
    endfunction

    // compare one returned result with the oldest pending score
    function void check_result(score_t score, status_t status);
      score_result_t want;
      if (due_scores.size() == 0) begin
        report($sformatf("result with none pending: score %0d status %0d", score, status));
        return;
      end
      want = due_scores.pop_front();
      if (want.score !== score || want.status !== status)
        report($sformatf("result mismatch: expected score %0d status %0d, got score %0d status %0d",
                         want.score, want.status, score, status));
    endfunction

    function int pending();
      return due_scores.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  fms_in_if  in_ch ();
  fms_out_if out_ch ();

  fuzzy_match_scorer_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  match_scoreboard sb = new();

  cp_t pat_q [$];
  cp_t separators [5] = '{CH_BSLASH, CH_SLASH, CH_SPACE, CH_UNDER, CH_DOT};
  int  items_sent;
  bit  no_idle;
  int  hold_request;
  int  idle_cycles;

  always #5ns clk = ~clk;

  function automatic cp_t flip_case(cp_t c);
    if (c >= 21'h41 && c <= 21'h5A) return c + 21'd32;
    if (c >= 21'h61 && c <= 21'h7A) return c - 21'd32;
    return c;
  endfunction

  // offer one request after a random gap and wait for its acceptance
  task automatic send_request(cmd_t cmd, cp_t cp, logic eot);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.cmd           <= cmd;
    in_ch.code_point    <= cp;
    in_ch.end_of_target <= eot;
    do @(negedge clk); while (in_ch.ready !== 1'b1);
    @(posedge clk);
    sb.take_request(cmd, cp, eot);
    case (cmd)
      CMD_APPEND: if (pat_q.size() < PATTERN_MAX) pat_q.insert(pat_q.size(), cp);
      CMD_CLEAR:  pat_q.delete();
      default: ;
    endcase
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  task automatic send_text(cmd_t cmd, string s, logic eot_last);
    for (int i = 0; i < s.len(); i++)
      send_request(cmd, cp_t'(s[i]), eot_last && (i == s.len() - 1));
  endtask

  // hold the request channel idle until every pending result is back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // clear, then append n random characters
  task automatic send_pattern(int n);
    cp_t c;
    int  r;
    send_request(CMD_CLEAR, cp_t'($urandom_range(0, CP_TOP)), 1'($urandom_range(0, 1)));
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        c = 21'h61 + cp_t'($urandom_range(0, 25));
        if ($urandom_range(0, 1)) c = flip_case(c);
      end else if (r < 85) begin
        c = separators[$urandom_range(0, 4)];
      end else begin
        c = cp_t'($urandom_range(0, CP_TOP));
      end
      send_request(CMD_APPEND, c, 1'($urandom_range(0, 1)));
    end
  endtask

  // stream a target; ordered targets take the pattern's characters in order
  task automatic send_target(int len, bit ordered, bit eot_last);
    cp_t c;
    int  r;
    int  next_pat;
    next_pat = 0;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (ordered && next_pat < pat_q.size() && $urandom_range(0, 2) != 0) begin
        c = pat_q[next_pat];
        next_pat++;
        if ($urandom_range(0, 3) == 0) c = flip_case(c);
      end else if (r < 45 && pat_q.size() > 0) begin
        c = pat_q[$urandom_range(0, pat_q.size() - 1)];
        if ($urandom_range(0, 1)) c = flip_case(c);
      end else if (r < 65) begin
        c = separators[$urandom_range(0, 4)];
      end else if (r < 95) begin
        c = 21'h61 + cp_t'($urandom_range(0, 25));
        if ($urandom_range(0, 1)) c = flip_case(c);
      end else begin
        c = cp_t'($urandom_range(0, CP_TOP));
      end
      send_request(CMD_TARGET, c, eot_last && (i == len - 1));
    end
  endtask

  // result receiver with random stalls and a single long hold-off
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(negedge clk); while (out_ch.valid !== 1'b1);
      @(posedge clk);
    end
  end

  // result check and watchdog, sampled mid-cycle while signals are stable
  always @(negedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        sb.check_result(out_ch.match_score, out_ch.status);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int kind;
    bit pressed;
    in_ch.valid         <= 1'b0;
    in_ch.cmd           <= CMD_APPEND;
    in_ch.code_point    <= '0;
    in_ch.end_of_target <= 1'b0;
    rst_n               <= 1'b0;
    items_sent   = 0;
    no_idle      = 1'b0;
    hold_request = 0;
    idle_cycles  = 0;
    pressed      = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // empty pattern, then an ignored command with end flag
    send_text(CMD_TARGET, "a", 1'b1);
    send_request(CMD_UNUSED, CP_TOP, 1'b1);
    // pattern load, end flag on an append is ignored
    send_text(CMD_APPEND, "aB", 1'b0);
    send_text(CMD_APPEND, "c", 1'b1);
    // pattern longer than target
    send_text(CMD_TARGET, "x", 1'b1);
    // first letter, case mismatch on every character
    send_text(CMD_TARGET, "AbC", 1'b1);
    // backslash, space and dot bonuses
    send_text(CMD_TARGET, "\\a B.c", 1'b1);
    // camel hump and run
    send_text(CMD_TARGET, "qaBc", 1'b1);
    // clear abandons a target in progress
    send_text(CMD_TARGET, "ab", 1'b0);
    send_request(CMD_CLEAR, CP_TOP, 1'b1);
    send_text(CMD_TARGET, "z", 1'b1);
    // top code point as pattern and target
    send_request(CMD_APPEND, CP_TOP, 1'b0);
    send_request(CMD_TARGET, CP_TOP, 1'b1);

    // random sequences
    while (items_sent < ITEM_GOAL) begin
      no_idle = (items_sent >= 600 && items_sent < 800);
      if (!pressed && items_sent >= 1000) begin
        // receiver holds off while results pile up, then a full drain
        hold_request = HOLD_CYCLES;
        repeat (6) send_target($urandom_range(1, 3), 1'b0, 1'b1);
        wait_drained();
        pressed = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        send_pattern(($urandom_range(0, 9) == 0) ? $urandom_range(30, 34)
                                                  : $urandom_range(0, 6));
      end else if (kind < 45) begin
        send_target(pat_q.size() + $urandom_range(1, 6), 1'b1, 1'b1);
      end else if (kind < 80) begin
        send_target(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(1, 12), 1'b0, 1'b1);
      end else if (kind < 90) begin
        // target cut short by a pattern change
        send_target($urandom_range(1, 5), 1'b0, 1'b0);
        send_request(CMD_APPEND, 21'h61 + cp_t'($urandom_range(0, 25)), 1'b1);
      end else begin
        repeat ($urandom_range(1, 4))
          send_request(cmd_t'($urandom_range(0, 3)), cp_t'($urandom_range(0, CP_TOP)),
                       1'($urandom_range(0, 1)));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
